### hw/rtl/sexl_pkg.sv
// Shared types and constants of the s-expression token lexer.
// Holds the result and queue entry structs, token kinds, error codes and byte codes.
// Depends on nothing.
package sexl_pkg;

  localparam int unsigned OffsetBits = 32;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned KindW  = 4;
  localparam int unsigned FieldW = 32;
  localparam int unsigned ValueW = 63;
  localparam int unsigned ErrW   = 2;

  localparam logic [ValueW-1:0] ValueMax = '1;

  localparam logic [KindW-1:0] KindSymbol  = 4'd0;
  localparam logic [KindW-1:0] KindInteger = 4'd1;
  localparam logic [KindW-1:0] KindKeyword = 4'd2;
  localparam logic [KindW-1:0] KindString  = 4'd3;
  localparam logic [KindW-1:0] KindLParen  = 4'd4;
  localparam logic [KindW-1:0] KindRParen  = 4'd5;
  localparam logic [KindW-1:0] KindLBrack  = 4'd6;
  localparam logic [KindW-1:0] KindRBrack  = 4'd7;
  localparam logic [KindW-1:0] KindLCurl   = 4'd8;
  localparam logic [KindW-1:0] KindRCurl   = 4'd9;
  localparam logic [KindW-1:0] KindError   = 4'd10;

  localparam logic [ErrW-1:0] ErrNone         = 2'd0;
  localparam logic [ErrW-1:0] ErrInvalidChar  = 2'd1;
  localparam logic [ErrW-1:0] ErrUnterminated = 2'd2;

  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharUnder  = 8'h5F;
  localparam logic [7:0] CharQuest  = 8'h3F;
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharLBrack = 8'h5B;
  localparam logic [7:0] CharRBrack = 8'h5D;
  localparam logic [7:0] CharLCurl  = 8'h7B;
  localparam logic [7:0] CharRCurl  = 8'h7D;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] length;
    logic [ValueW-1:0] value;
    logic [ErrW-1:0]   err;
  } res_t;

  typedef struct packed {
    logic           two;
    res_t [1:0]     slot;
  } entry_t;

endpackage

### hw/rtl/sexl_front.sv
// Front part of the lexer: accepts source bytes, keeps the scanner state and
// builds one queue entry with up to two results per byte.
// Depends on sexl_pkg.
module sexl_front #(
  parameter int unsigned OffsetBits = sexl_pkg::OffsetBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_input_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output sexl_pkg::entry_t q_data_o
);

  localparam logic [2:0] ModeIdle = 3'd0;
  localparam logic [2:0] ModeSym  = 3'd1;
  localparam logic [2:0] ModeInt  = 3'd2;
  localparam logic [2:0] ModeKey  = 3'd3;
  localparam logic [2:0] ModeStr  = 3'd4;
  localparam logic [2:0] ModeErr  = 3'd5;

  localparam logic [OffsetBits-1:0] OffOne = {{(OffsetBits-1){1'b0}}, 1'b1};

  logic [2:0]                      mode_q, mode_d;
  logic [OffsetBits-1:0]           begin_q, begin_d;
  logic [OffsetBits-1:0]           off_q, off_d;
  logic [sexl_pkg::ValueW-1:0]     acc_q, acc_d;
  logic [sexl_pkg::ValueW+3:0]     prod;
  logic [1:0]                      nres;
  sexl_pkg::res_t [1:0]            slot;
  logic                            taken, more, accept;
  logic                            is_alpha, is_digit, is_space, is_head, is_rest;
  logic [7:0]                      c;

  function automatic sexl_pkg::res_t make_res(
    input logic [sexl_pkg::KindW-1:0]  kind,
    input logic [OffsetBits-1:0]       start,
    input logic [OffsetBits-1:0]       length,
    input logic [sexl_pkg::ValueW-1:0] value,
    input logic [sexl_pkg::ErrW-1:0]   err
  );
    sexl_pkg::res_t r;
    r.kind   = kind;
    r.start  = sexl_pkg::FieldW'(start);
    r.length = sexl_pkg::FieldW'(length);
    r.value  = value;
    r.err    = err;
    return r;
  endfunction

  function automatic sexl_pkg::res_t open_res(
    input logic [2:0]                  mode,
    input logic [OffsetBits-1:0]       start,
    input logic [OffsetBits-1:0]       stop,
    input logic [sexl_pkg::ValueW-1:0] value
  );
    sexl_pkg::res_t r;
    case (mode)
      ModeInt: r = make_res(sexl_pkg::KindInteger, start, stop - start, value,
                            sexl_pkg::ErrNone);
      ModeKey: r = make_res(sexl_pkg::KindKeyword, start, stop - start, '0,
                            sexl_pkg::ErrNone);
      default: r = make_res(sexl_pkg::KindSymbol, start, stop - start, '0,
                            sexl_pkg::ErrNone);
    endcase
    return r;
  endfunction

  assign c        = char_code_i;
  assign is_alpha = (c >= sexl_pkg::CharLowA && c <= sexl_pkg::CharLowZ) ||
                    (c >= sexl_pkg::CharUpA && c <= sexl_pkg::CharUpZ);
  assign is_digit = c >= sexl_pkg::CharZero && c <= sexl_pkg::CharNine;
  assign is_space = c == sexl_pkg::CharSpace ||
                    (c >= sexl_pkg::CharTab && c <= sexl_pkg::CharCr);
  assign is_head  = is_alpha || c == sexl_pkg::CharStar || c == sexl_pkg::CharPlus ||
                    c == sexl_pkg::CharBang || c == sexl_pkg::CharMinus ||
                    c == sexl_pkg::CharUnder || c == sexl_pkg::CharQuest ||
                    c == sexl_pkg::CharGt || c == sexl_pkg::CharLt ||
                    c == sexl_pkg::CharEq || c == sexl_pkg::CharDollar;
  assign is_rest  = is_head || is_digit || c == sexl_pkg::CharDot ||
                    c == sexl_pkg::CharHash;

  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                {{(sexl_pkg::ValueW){1'b0}}, c[3:0]};

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    mode_d  = mode_q;
    begin_d = begin_q;
    off_d   = off_q;
    acc_d   = acc_q;
    taken   = 1'b0;
    more    = 1'b0;
    nres    = 2'd0;
    slot    = '0;

    case (mode_q)
      ModeErr: begin
        taken = 1'b1;
      end
      ModeStr: begin
        taken = 1'b1;
        if (c == sexl_pkg::CharQuote) begin
          slot[nres[0]] = make_res(sexl_pkg::KindString, begin_q + OffOne,
                                   off_q - begin_q - OffOne, '0, sexl_pkg::ErrNone);
          nres   = nres + 2'd1;
          mode_d = ModeIdle;
        end
      end
      ModeSym, ModeKey: begin
        more = (mode_q == ModeSym) ? is_rest : (is_alpha || is_digit);
        if (more) begin
          taken = 1'b1;
        end else begin
          slot[nres[0]] = open_res(mode_q, begin_q, off_q, acc_q);
          nres   = nres + 2'd1;
          mode_d = ModeIdle;
        end
      end
      ModeInt: begin
        if (is_digit) begin
          acc_d = (prod[sexl_pkg::ValueW+3:sexl_pkg::ValueW] != 4'd0) ?
                  sexl_pkg::ValueMax : prod[sexl_pkg::ValueW-1:0];
          taken = 1'b1;
        end else begin
          slot[nres[0]] = open_res(mode_q, begin_q, off_q, acc_q);
          nres   = nres + 2'd1;
          mode_d = ModeIdle;
        end
      end
      default: begin
      end
    endcase

    if (!taken && !is_space) begin
      begin_d = off_q;
      if (is_head) begin
        mode_d = ModeSym;
      end else if (is_digit) begin
        mode_d = ModeInt;
        acc_d  = {{(sexl_pkg::ValueW-4){1'b0}}, c[3:0]};
      end else if (c == sexl_pkg::CharColon) begin
        mode_d = ModeKey;
      end else if (c == sexl_pkg::CharQuote) begin
        mode_d = ModeStr;
      end else if (c == sexl_pkg::CharLParen) begin
        slot[nres[0]] = make_res(sexl_pkg::KindLParen, off_q, OffOne, '0, sexl_pkg::ErrNone);
        nres = nres + 2'd1;
      end else if (c == sexl_pkg::CharRParen) begin
        slot[nres[0]] = make_res(sexl_pkg::KindRParen, off_q, OffOne, '0, sexl_pkg::ErrNone);
        nres = nres + 2'd1;
      end else if (c == sexl_pkg::CharLBrack) begin
        slot[nres[0]] = make_res(sexl_pkg::KindLBrack, off_q, OffOne, '0, sexl_pkg::ErrNone);
        nres = nres + 2'd1;
      end else if (c == sexl_pkg::CharRBrack) begin
        slot[nres[0]] = make_res(sexl_pkg::KindRBrack, off_q, OffOne, '0, sexl_pkg::ErrNone);
        nres = nres + 2'd1;
      end else if (c == sexl_pkg::CharLCurl) begin
        slot[nres[0]] = make_res(sexl_pkg::KindLCurl, off_q, OffOne, '0, sexl_pkg::ErrNone);
        nres = nres + 2'd1;
      end else if (c == sexl_pkg::CharRCurl) begin
        slot[nres[0]] = make_res(sexl_pkg::KindRCurl, off_q, OffOne, '0, sexl_pkg::ErrNone);
        nres = nres + 2'd1;
      end else begin
        slot[nres[0]] = make_res(sexl_pkg::KindError, off_q, OffOne, '0,
                                 sexl_pkg::ErrInvalidChar);
        nres   = nres + 2'd1;
        mode_d = ModeErr;
      end
    end

    if (end_of_input_i) begin
      if (mode_d == ModeStr) begin
        slot[nres[0]] = make_res(sexl_pkg::KindError, begin_d, off_q + OffOne - begin_d,
                                 '0, sexl_pkg::ErrUnterminated);
        nres = nres + 2'd1;
      end else if (mode_d == ModeSym || mode_d == ModeInt || mode_d == ModeKey) begin
        slot[nres[0]] = open_res(mode_d, begin_d, off_q + OffOne, acc_d);
        nres = nres + 2'd1;
      end
      mode_d  = ModeIdle;
      begin_d = '0;
      off_d   = '0;
      acc_d   = '0;
    end else begin
      off_d = off_q + OffOne;
    end
  end

  assign q_push_o      = accept && (nres != 2'd0);
  assign q_data_o.two  = nres[1];
  assign q_data_o.slot = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      begin_q <= '0;
      off_q   <= '0;
      acc_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      off_q   <= off_d;
      acc_q   <= acc_d;
    end
  end

endmodule

### hw/rtl/sexl_fifo.sv
// Short queue of result entries between the front and back parts of the lexer.
// First-word-fall-through; depth comes from the package.
// Depends on sexl_pkg.
module sexl_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sexl_pkg::entry_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output sexl_pkg::entry_t data_o
);

  localparam int unsigned PtrW = (sexl_pkg::QueueDepth > 1) ?
                                 $clog2(sexl_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(sexl_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(sexl_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(sexl_pkg::QueueDepth);

  sexl_pkg::entry_t mem_q [sexl_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntFull;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/sexl_back.sv
// Back part of the lexer: takes queue entries apart into single results and
// holds each in an output register until the receiver takes it.
// Depends on sexl_pkg.
module sexl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  sexl_pkg::entry_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sexl_pkg::res_t   res_o,
  output logic             last_o
);

  logic           out_valid_q;
  logic           idx_q;
  logic           load, is_last;
  sexl_pkg::res_t res_q;
  logic           last_q;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = idx_q || !q_data_i.two;
  assign q_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= !is_last;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= q_data_i.slot[idx_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/sexpr_token_lexer.sv
// Top level of the s-expression token lexer: front scanner, entry queue and
// result back part.
// Depends on sexl_pkg, sexl_front, sexl_fifo and sexl_back.
//
// The input channel takes one source byte per item with a flag on the final
// byte of the text. The output channel gives one token result per item:
// kind, start offset, length, integer value, error code, and a flag on the
// final result caused by one input byte. Both channels use valid and ready.
// A byte is accepted in the cycle it is offered while the four-entry queue
// has room; its results pass through the queue and then the output register.
// One byte is taken per cycle while the queue has room. A byte with two
// results loads the single output register twice, so the sustained rate is
// one result per cycle while the receiver is ready. When the receiver
// stalls, the output register holds its result and the queue fills; once it
// is full, input ready drops until the queue drains. Reset empties the queue
// and output register and returns the scanner to offset zero between tokens;
// the same happens to the scanner after each final byte.
module sexpr_token_lexer #(
  parameter int unsigned OffsetBits = sexl_pkg::OffsetBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          end_of_input_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sexl_pkg::KindW-1:0]    token_kind_o,
  output logic [sexl_pkg::FieldW-1:0]   token_start_o,
  output logic [sexl_pkg::FieldW-1:0]   token_length_o,
  output logic [sexl_pkg::ValueW-1:0]   integer_value_o,
  output logic [sexl_pkg::ErrW-1:0]     error_code_o,
  output logic                          last_of_run_o
);

  logic             q_full, q_push, q_valid, q_pop;
  sexl_pkg::entry_t q_wdata, q_rdata;
  sexl_pkg::res_t   res;

  sexl_front #(
    .OffsetBits(OffsetBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_code_i   (char_code_i),
    .end_of_input_i(end_of_input_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  sexl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_rdata)
  );

  sexl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res),
    .last_o     (last_of_run_o)
  );

  assign token_kind_o    = res.kind;
  assign token_start_o   = res.start;
  assign token_length_o  = res.length;
  assign integer_value_o = res.value;
  assign error_code_o    = res.err;

endmodule
